// ----- rtl/core/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared sizes, operation codes and the B3/S23 cell rule for the grid step.
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    localparam int OP_W  = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 6;

    localparam int ROW_AW = $clog2(GRID_HEIGHT);
    localparam int COL_AW = $clog2(GRID_WIDTH);
    localparam int CNT_W  = $clog2(GRID_HEIGHT + 1);

    localparam logic [3:0] SURVIVE_MIN = 4'd2;
    localparam logic [3:0] DEATH_CNT   = 4'd4;
    localparam logic [3:0] BIRTH_CNT   = 4'd3;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_STEP   = 2'd2,
        OP_NONE   = 2'd3
    } lgs_op_t;

    typedef logic [GRID_WIDTH-1:0] lgs_row_t;

    typedef struct packed {
        logic shift;
    } lgs_win_ctrl_t;

    function automatic logic [3:0] nbr_count(input logic [7:0] nb);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, nb[i]};
        end
        return n;
    endfunction

    function automatic logic life_rule(input logic alive, input logic [3:0] n);
        logic nxt;
        if (alive)
        begin
            nxt = (n >= SURVIVE_MIN) && (n < DEATH_CNT);
        end
        else
        begin
            nxt = (n == BIRTH_CNT);
        end
        return nxt;
    endfunction

endpackage

// ----- rtl/core/lgs_cmd_if.sv -----
// ----------------------------------------------------------------------------
// lgs_cmd_if
// Command channel: operation with cell coordinates.
// ----------------------------------------------------------------------------
interface lgs_cmd_if;
    logic                     valid;
    logic                     ready;
    logic [lgs_pkg::OP_W-1:0]  op;
    logic [lgs_pkg::ROW_W-1:0] row;
    logic [lgs_pkg::COL_W-1:0] col;

    modport source (output valid, output op, output row, output col, input ready);
    modport sink   (input valid, input op, input row, input col, output ready);
endinterface

// ----- rtl/core/lgs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lgs_rsp_if
// Response channel: cell value and range flag, one beat per command.
// ----------------------------------------------------------------------------
interface lgs_rsp_if;
    logic valid;
    logic ready;
    logic cell_value;
    logic range_error;

    modport source (output valid, output cell_value, output range_error, input ready);
    modport sink   (input valid, input cell_value, input range_error, output ready);
endinterface

// ----- rtl/core/lgs_ram.sv -----
// ----------------------------------------------------------------------------
// lgs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/lgs_row_calc.sv -----
// ----------------------------------------------------------------------------
// lgs_row_calc
// Three-row window over the grid sweep and the next-generation row logic.
// ----------------------------------------------------------------------------
module lgs_row_calc (
    input  logic                  clk,
    input  lgs_pkg::lgs_win_ctrl_t ctrl,
    input  lgs_pkg::lgs_row_t      row_in,
    output lgs_pkg::lgs_row_t      next_row
);

    lgs_pkg::lgs_row_t prev_reg;
    lgs_pkg::lgs_row_t cur_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= row_in;
        end
    end

    // row_in is the row below cur_reg; border columns pass through
    always_comb
    begin
        next_row = cur_reg;
        for (int c = 1; c < lgs_pkg::GRID_WIDTH - 1; c++)
        begin
            next_row[c] = lgs_pkg::life_rule(cur_reg[c],
                lgs_pkg::nbr_count({prev_reg[c-1 +: 3], row_in[c-1 +: 3],
                                    cur_reg[c-1], cur_reg[c+1]}));
        end
    end

endmodule

// ----- rtl/core/life_grid_generation_step.sv -----
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Game of Life (B3/S23) grid held in one RAM row per grid row; read, toggle
// and single-generation step commands.
// ----------------------------------------------------------------------------
// One command is handled at a time and each gives one response beat. A read
// or toggle in range goes through the cell and completion states to its response;
// a step sweeps the grid, reading one grid row per cycle through the single
// read port of the grid RAM, and writes each interior row back once it has
// passed the RAM read register and the current-row register of the window.
// The next command is taken once the response is in the output register.
// After reset the grid reads as all dead at once: a per-row written flag
// masks RAM rows never written, so there is no clearing pass.
// ----------------------------------------------------------------------------
module life_grid_generation_step (
    input  logic       clk,
    input  logic       rst_n,
    lgs_cmd_if.sink    cmd,
    lgs_rsp_if.source  rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CELL = 4'b0010,
        S_STEP = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [lgs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [lgs_pkg::ROW_AW-1:0] row_reg, row_next;
    logic [lgs_pkg::COL_AW-1:0] col_reg, col_next;
    logic                       toggle_reg, toggle_next;
    logic                       pend_value_reg, pend_value_next;
    logic                       pend_error_reg, pend_error_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    logic                       rsp_value_reg, rsp_value_next;
    logic                       rsp_error_reg, rsp_error_next;
    logic [lgs_pkg::GRID_HEIGHT-1:0] written_reg, written_next;
    logic                       rvalid_reg, rvalid_next;

    logic                       ram_we;
    logic [lgs_pkg::ROW_AW-1:0] ram_waddr;
    lgs_pkg::lgs_row_t          ram_wdata;
    logic                       ram_re;
    logic [lgs_pkg::ROW_AW-1:0] ram_raddr;
    lgs_pkg::lgs_row_t          ram_rdata;
    lgs_pkg::lgs_row_t          row_data;
    lgs_pkg::lgs_row_t          calc_row;
    lgs_pkg::lgs_win_ctrl_t     win_ctrl;

    logic accept;
    logic out_range;
    logic rsp_free;
    logic cell_bit;
    logic [lgs_pkg::CNT_W-1:0] wr_row;

    lgs_ram #(
        .WIDTH (lgs_pkg::GRID_WIDTH),
        .DEPTH (lgs_pkg::GRID_HEIGHT)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lgs_row_calc u_row_calc (
        .clk      (clk),
        .ctrl     (win_ctrl),
        .row_in   (row_data),
        .next_row (calc_row)
    );

    assign row_data = ram_rdata & {lgs_pkg::GRID_WIDTH{rvalid_reg}};

    assign accept    = cmd.valid && cmd.ready;
    assign out_range = ({1'b0, cmd.row} >= (lgs_pkg::ROW_W + 1)'(lgs_pkg::GRID_HEIGHT))
                    || ({1'b0, cmd.col} >= (lgs_pkg::COL_W + 1)'(lgs_pkg::GRID_WIDTH));
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign cell_bit  = row_data[col_reg];
    assign wr_row    = cnt_reg - lgs_pkg::CNT_W'(2);

    assign cmd.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.cell_value  = rsp_value_reg;
    assign rsp.range_error = rsp_error_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        toggle_next     = toggle_reg;
        pend_value_next = pend_value_reg;
        pend_error_next = pend_error_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_value_next  = rsp_value_reg;
        rsp_error_next  = rsp_error_reg;
        written_next    = written_reg;
        ram_we          = 1'b0;
        ram_waddr       = row_reg;
        ram_wdata       = row_data;
        ram_re          = 1'b0;
        ram_raddr       = cmd.row[lgs_pkg::ROW_AW-1:0];
        win_ctrl.shift  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    row_next        = cmd.row[lgs_pkg::ROW_AW-1:0];
                    col_next        = cmd.col[lgs_pkg::COL_AW-1:0];
                    cnt_next        = '0;
                    pend_value_next = 1'b0;
                    pend_error_next = 1'b0;
                    toggle_next     = 1'b0;
                    case (lgs_pkg::lgs_op_t'(cmd.op))
                        lgs_pkg::OP_READ, lgs_pkg::OP_TOGGLE:
                        begin
                            if (out_range)
                            begin
                                pend_error_next = 1'b1;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                toggle_next = (lgs_pkg::lgs_op_t'(cmd.op) == lgs_pkg::OP_TOGGLE);
                                ram_re      = 1'b1;
                                state_next  = S_CELL;
                            end
                        end
                        lgs_pkg::OP_STEP:
                        begin
                            state_next = S_STEP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CELL:
            begin
                pend_value_next = cell_bit ^ toggle_reg;
                if (toggle_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = row_reg;
                    ram_wdata = row_data ^ (lgs_pkg::GRID_WIDTH'(1) << col_reg);
                end
                state_next = S_DONE;
            end
            S_STEP:
            begin
                // read row cnt, window sees row cnt-1, write back row cnt-2
                ram_raddr      = cnt_reg[lgs_pkg::ROW_AW-1:0];
                ram_re         = (cnt_reg < lgs_pkg::CNT_W'(lgs_pkg::GRID_HEIGHT));
                win_ctrl.shift = (cnt_reg != '0);
                ram_waddr      = wr_row[lgs_pkg::ROW_AW-1:0];
                ram_wdata      = calc_row;
                ram_we         = (cnt_reg >= lgs_pkg::CNT_W'(3));
                cnt_next       = cnt_reg + lgs_pkg::CNT_W'(1);
                if (cnt_reg == lgs_pkg::CNT_W'(lgs_pkg::GRID_HEIGHT))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_value_next = pend_value_reg;
                    rsp_error_next = pend_error_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            written_next[ram_waddr] = 1'b1;
        end
    end

    assign rvalid_next = ram_re ? written_reg[ram_raddr] : rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            written_reg   <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            written_reg   <= written_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        toggle_reg     <= toggle_next;
        pend_value_reg <= pend_value_next;
        pend_error_reg <= pend_error_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_error_reg  <= rsp_error_next;
        rvalid_reg     <= rvalid_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("command accepted but sequencer stayed idle");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CELL || state_reg == S_STEP))
        else $error("grid write outside cell or step phase");

    a_step_keeps_border: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_STEP) |->
            (ram_waddr != '0 &&
             ram_waddr != lgs_pkg::ROW_AW'(lgs_pkg::GRID_HEIGHT - 1)))
        else $error("step wrote a border row");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rsp_valid_reg)) |-> ($past(state_reg) == S_DONE))
        else $error("response raised outside completion");

endmodule
